// ===== sv/krt_pkg.sv =====
// Shared types and constants for the keyed record table.
// Used by krt_mem, krt_ctrl and keyed_record_table; no other dependencies.
`timescale 1ns / 1ps

package krt_pkg;

  localparam int TABLE_DEPTH_DEF = 512;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 19;
  localparam int SEX_W    = 2;
  localparam int AGE_W    = 7;
  localparam int INDEX_W  = 9;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 9;
  localparam int FILL_W   = 10;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_SORT   = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_BEYOND    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD_WAIT,
    S_SORT_FETCH,
    S_SORT_INNER,
    S_SORT_STORE
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SEX_W-1:0] sex;
    logic [AGE_W-1:0] age;
  } rec_t;

endpackage

// ===== sv/keyed_record_table.sv =====
// Top level of the keyed record table: sequencer plus record memory.
// Depends on krt_pkg, krt_mem and krt_ctrl.
//
// Channel  | Handshake               | Payload
// ---------+-------------------------+---------------------------------------------
// command  | start high, busy low    | op_i, key_i, sex_i, age_i, index_i
// result   | done_o, one cycle       | status_o, position_o, rec_*_o, fill_count_o
//
// Insert, unused codes, out-of-range read: result registered from S_IDLE.
// In-range read: via S_RD_WAIT. Search and delete: one memory read per cycle.
// Sort of two or more records: S_SORT_FETCH, S_SORT_INNER, S_SORT_STORE; the single
// memory port pair sets the pace of every walk.
// Reset clears the fill count and the sequencer; the memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module keyed_record_table #(
  parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [krt_pkg::OP_W-1:0]       op_i,
  input  logic [krt_pkg::KEY_W-1:0]      key_i,
  input  logic [krt_pkg::SEX_W-1:0]      sex_i,
  input  logic [krt_pkg::AGE_W-1:0]      age_i,
  input  logic [krt_pkg::INDEX_W-1:0]    index_i,
  output logic                           done_o,
  output logic [krt_pkg::STATUS_W-1:0]   status_o,
  output logic [krt_pkg::POS_W-1:0]      position_o,
  output logic [krt_pkg::KEY_W-1:0]      rec_key_o,
  output logic [krt_pkg::SEX_W-1:0]      rec_sex_o,
  output logic [krt_pkg::AGE_W-1:0]      rec_age_o,
  output logic [krt_pkg::FILL_W-1:0]     fill_count_o
);
  import krt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [AW-1:0]  mem_raddr;
  rec_t           mem_wdata;
  rec_t           mem_rdata;
  rec_t           rec;
  status_e        status;

  krt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  krt_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .key_i        (key_i),
    .sex_i        (sex_i),
    .age_i        (age_i),
    .index_i      (index_i),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .done_o       (done_o),
    .status_o     (status),
    .position_o   (position_o),
    .rec_o        (rec),
    .fill_count_o (fill_count_o)
  );

  assign status_o  = status;
  assign rec_key_o = rec.key;
  assign rec_sex_o = rec.sex;
  assign rec_age_o = rec.age;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while sequencer busy");

  a_err_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_OK) |->
      (position_o == '0 && rec_key_o == '0 && rec_sex_o == '0 && rec_age_o == '0))
    else $error("error result carries record fields");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (TABLE_DEPTH < 1024 && start && !busy && op_i == OP_INSERT &&
     32'(fill_count_o) < TABLE_DEPTH) |=>
      (done_o && status_o == STAT_OK && fill_count_o == $past(fill_count_o) + 10'd1))
    else $error("insert below capacity did not append");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (TABLE_DEPTH < 1024 && done_o && status_o == STAT_FULL) |->
      (32'(fill_count_o) == TABLE_DEPTH))
    else $error("full status with table not full");
`endif

endmodule

// ===== sv/krt_mem.sv =====
// Record memory: one write port, one read port, read data registered.
// Depends on krt_pkg for the record type.
`timescale 1ns / 1ps

module krt_mem #(
  parameter int DEPTH = krt_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(krt_pkg::TABLE_DEPTH_DEF)
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  krt_pkg::rec_t  wdata_i,
  input  logic [AW-1:0]  raddr_i,
  output krt_pkg::rec_t  rdata_o
);
  import krt_pkg::*;

  rec_t mem_q [DEPTH];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/krt_ctrl.sv =====
// Operation sequencer: read-modify-write walks over the record memory.
// Depends on krt_pkg; drives the ports of krt_mem.
`timescale 1ns / 1ps

module krt_ctrl #(
  parameter int DEPTH = krt_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(krt_pkg::TABLE_DEPTH_DEF),
  parameter int CW    = $clog2(krt_pkg::TABLE_DEPTH_DEF + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [krt_pkg::OP_W-1:0]     op_i,
  input  logic [krt_pkg::KEY_W-1:0]    key_i,
  input  logic [krt_pkg::SEX_W-1:0]    sex_i,
  input  logic [krt_pkg::AGE_W-1:0]    age_i,
  input  logic [krt_pkg::INDEX_W-1:0]  index_i,
  output logic                         mem_we_o,
  output logic [AW-1:0]                mem_waddr_o,
  output krt_pkg::rec_t                mem_wdata_o,
  output logic [AW-1:0]                mem_raddr_o,
  input  krt_pkg::rec_t                mem_rdata_i,
  output logic                         done_o,
  output krt_pkg::status_e             status_o,
  output logic [krt_pkg::POS_W-1:0]    position_o,
  output krt_pkg::rec_t                rec_o,
  output logic [krt_pkg::FILL_W-1:0]   fill_count_o
);
  import krt_pkg::*;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]       didx_q, didx_d;
  logic [CW-1:0]       i_q, i_d;
  logic                vld_q, vld_d;
  logic                del_q, del_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [INDEX_W-1:0]  idx_q, idx_d;
  rec_t                rec_i_q, rec_i_d;
  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  rec_t                rec_q, rec_d;

  logic [31:0]         didx_ext, idx_ext, cnt_ext;
  logic                match, last, less, rd_more, rd_in_range, sort_end;
  logic [CW-1:0]       w_fin;

  assign didx_ext    = 32'(didx_q);
  assign idx_ext     = 32'(index_i);
  assign cnt_ext     = 32'(cnt_q);
  assign match       = mem_rdata_i.key == key_q;
  assign less        = mem_rdata_i.key < rec_i_q.key;
  assign last        = didx_q == (cnt_q - CW'(1));
  assign rd_more     = rd_ptr_q < cnt_q;
  assign rd_in_range = idx_ext < cnt_ext;
  assign sort_end    = (i_q + CW'(2)) == cnt_q;
  assign w_fin       = match ? wr_ptr_q : (wr_ptr_q + CW'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (op_i)
            OP_DELETE, OP_SEARCH: begin
              if (cnt_q != '0) state_d = S_SCAN;
            end
            OP_SORT: begin
              if (cnt_q >= CW'(2)) state_d = S_SORT_FETCH;
            end
            OP_READ: begin
              if (rd_in_range) state_d = S_RD_WAIT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (vld_q && (last || (!del_q && match))) state_d = S_IDLE;
      end
      S_RD_WAIT:    state_d = S_IDLE;
      S_SORT_FETCH: state_d = S_SORT_INNER;
      S_SORT_INNER: begin
        if (vld_q && last) state_d = S_SORT_STORE;
      end
      S_SORT_STORE: state_d = sort_end ? S_IDLE : S_SORT_FETCH;
      default:      state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cnt_d       = cnt_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    didx_d      = didx_q;
    i_d         = i_q;
    vld_d       = 1'b0;
    del_d       = del_q;
    key_d       = key_q;
    idx_d       = idx_q;
    rec_i_d     = rec_i_q;
    done_d      = 1'b0;
    status_d    = status_q;
    pos_d       = pos_q;
    rec_d       = rec_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_ptr_q[AW-1:0];
    mem_wdata_o = rec_i_q;
    mem_raddr_o = rd_ptr_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          key_d    = key_i;
          del_d    = op_i == OP_DELETE;
          idx_d    = index_i;
          pos_d    = '0;
          rec_d    = '0;
          status_d = STAT_OK;
          case (op_i)
            OP_INSERT: begin
              done_d = 1'b1;
              if (cnt_q == DEPTH_C) begin
                status_d = STAT_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = cnt_q[AW-1:0];
                mem_wdata_o = '{key: key_i, sex: sex_i, age: age_i};
                cnt_d       = cnt_q + CW'(1);
              end
            end
            OP_DELETE, OP_SEARCH: begin
              if (cnt_q == '0) begin
                done_d   = 1'b1;
                status_d = STAT_NOT_FOUND;
              end else begin
                mem_raddr_o = '0;
                rd_ptr_d    = CW'(1);
                wr_ptr_d    = '0;
                didx_d      = '0;
                vld_d       = 1'b1;
              end
            end
            OP_SORT: begin
              if (cnt_q < CW'(2)) begin
                done_d = 1'b1;
              end else begin
                mem_raddr_o = '0;
                i_d         = '0;
              end
            end
            OP_READ: begin
              if (rd_in_range) begin
                mem_raddr_o = idx_ext[AW-1:0];
              end else begin
                done_d   = 1'b1;
                status_d = STAT_BEYOND;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end

      S_SCAN: begin
        if (rd_more) begin
          mem_raddr_o = rd_ptr_q[AW-1:0];
          rd_ptr_d    = rd_ptr_q + CW'(1);
          didx_d      = rd_ptr_q;
          vld_d       = 1'b1;
        end
        if (vld_q) begin
          if (!del_q) begin
            if (match) begin
              done_d   = 1'b1;
              status_d = STAT_OK;
              pos_d    = didx_ext[POS_W-1:0];
              rec_d    = mem_rdata_i;
            end else if (last) begin
              done_d   = 1'b1;
              status_d = STAT_NOT_FOUND;
            end
          end else begin
            // compact: keep non-matching records in order
            if (!match) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = wr_ptr_q[AW-1:0];
              mem_wdata_o = mem_rdata_i;
              wr_ptr_d    = wr_ptr_q + CW'(1);
            end
            if (last) begin
              done_d = 1'b1;
              if (w_fin == cnt_q) begin
                status_d = STAT_NOT_FOUND;
              end else begin
                status_d = STAT_OK;
                cnt_d    = w_fin;
              end
            end
          end
        end
      end

      S_RD_WAIT: begin
        done_d   = 1'b1;
        status_d = STAT_OK;
        pos_d    = idx_q;
        rec_d    = mem_rdata_i;
      end

      S_SORT_FETCH: begin
        rec_i_d     = mem_rdata_i;
        mem_raddr_o = i_q[AW-1:0] + AW'(1);
        rd_ptr_d    = i_q + CW'(2);
        didx_d      = i_q + CW'(1);
        vld_d       = 1'b1;
      end

      S_SORT_INNER: begin
        if (rd_more) begin
          mem_raddr_o = rd_ptr_q[AW-1:0];
          rd_ptr_d    = rd_ptr_q + CW'(1);
          didx_d      = rd_ptr_q;
          vld_d       = 1'b1;
        end
        // swap: hold the smaller record, write the larger one back
        if (vld_q && less) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = didx_q[AW-1:0];
          mem_wdata_o = rec_i_q;
          rec_i_d     = mem_rdata_i;
        end
      end

      S_SORT_STORE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = i_q[AW-1:0];
        mem_wdata_o = rec_i_q;
        i_d         = i_q + CW'(1);
        mem_raddr_o = i_q[AW-1:0] + AW'(1);
        if (sort_end) begin
          done_d   = 1'b1;
          status_d = STAT_OK;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    didx_q   <= didx_d;
    i_q      <= i_d;
    del_q    <= del_d;
    key_q    <= key_d;
    idx_q    <= idx_d;
    rec_i_q  <= rec_i_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    rec_q    <= rec_d;
  end

  assign busy         = state_q != S_IDLE;
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign position_o   = pos_q;
  assign rec_o        = rec_q;
  assign fill_count_o = cnt_ext[FILL_W-1:0];

endmodule
